### sv/ppv_pkg.sv
package ppv_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STAGES  = 24;
  localparam int QUOT_BITS    = FRAC_BITS + 2;
  localparam int DIV_LAT      = QUOT_BITS + 1;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int LEN_W        = 25;
  localparam int DIVIDEND_W   = 16 + FRAC_BITS + 8 + 1;
  localparam int CS_W         = FRAC_BITS + 4;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam longint ONE_Q  = 64'sd1 <<< FRAC_BITS;
  localparam longint SAT_HI = (ONE_Q < 32767) ? ONE_Q : 32767;
  localparam longint SAT_LO = (ONE_Q < 32768) ? -ONE_Q : -32768;

  typedef logic [31:0] atan_tab_t [CORDIC_STEPS];

  localparam atan_tab_t ATAN_TURN = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [15:0] kx;
    logic signed [15:0] ky;
    logic signed [15:0] kz;
  } dir_t;

  typedef struct packed {
    logic signed [CS_W-1:0] co;
    logic signed [CS_W-1:0] si;
  } cs_t;

  // round v / 2^s to nearest, halves away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic [63:0] mag;
    logic [63:0] half;
    half = (s == 0) ? 64'd0 : (64'd1 << (s - 1));
    mag  = v[63] ? 64'(-v) : 64'(v);
    mag  = (mag + half) >> s;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (c > SAT_HI) c = SAT_HI;
    if (c < SAT_LO) c = SAT_LO;
    return c[15:0];
  endfunction

endpackage

### sv/photon_polarization_vector.sv
// Linear polarization vector of an optical photon.
// Input stream (s_axis): one transaction per photon. tdata carries the unit
// direction (dir_x, dir_y, dir_z, signed Q1.14) and turn_angle (fraction of
// a full turn); tuser is the optical-photon flag. A transaction with tuser
// low is consumed and produces nothing.
// Output stream (m_axis): tdata carries pol_x, pol_y, pol_z (signed Q1.14,
// saturated to +-1.0).
// Throughput: one transaction per cycle while the pipeline is not stalled.
// From input acceptance to the output register a result passes the input
// register and the squared-length stage (2), the square root (24 bit-stages),
// the normalizing divide (17 stages), then the cross products, their
// rounding, the angle multiplies and the final round/saturate register (4);
// the 32-stage CORDIC runs alongside.
// The pipeline advances as a whole: when the output holds an unaccepted
// result and m_axis_tready is low, every stage holds and s_axis_tready
// drops; bubbles are not squeezed out. Reset clears all valid bits; data
// registers are not reset.
module photon_polarization_vector (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // dir_x, dir_y, dir_z, turn_angle
  input  logic        s_axis_tuser,  // is_optical_photon
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // pol_x, pol_y, pol_z
);

  localparam int F      = ppv_pkg::FRAC_BITS;
  localparam int QB     = ppv_pkg::QUOT_BITS;
  localparam int CW     = ppv_pkg::CS_W;
  localparam int T_SQ   = 1 + ppv_pkg::SQRT_STAGES;
  localparam int T_DIV  = T_SQ + ppv_pkg::DIV_LAT;
  localparam int VLAT   = T_DIV + 4;
  localparam int CS_DLY = T_DIV + 2 - ppv_pkg::CORDIC_LAT;
  localparam int Z_DLY  = ppv_pkg::DIV_LAT;

  logic                       en;
  logic [VLAT:0]              vld;
  ppv_pkg::dir_t              dl [0:T_DIV];
  logic [15:0]                ang0;
  logic [31:0]                m2;
  logic [ppv_pkg::LEN_W-1:0]  len;
  logic signed [QB:0]         ey_d;
  logic signed [QB:0]         ez_d;
  logic signed [16:0]         num_y;
  logic signed [16:0]         num_z;
  logic                       zl [0:Z_DLY-1];
  ppv_pkg::cs_t               cs_c;
  ppv_pkg::cs_t               csl [0:CS_DLY-1];
  logic signed [QB:0]         ey_f;
  logic signed [QB:0]         ez_f;
  logic signed [QB:0]         ey43;
  logic signed [QB:0]         ez43;
  logic signed [QB:0]         ey44;
  logic signed [QB:0]         ez44;
  logic signed [QB+16:0]      pa;
  logic signed [QB+16:0]      pb;
  logic signed [QB+16:0]      pc;
  logic signed [QB+16:0]      pd;
  logic signed [19:0]         px;
  logic signed [19:0]         py;
  logic signed [19:0]         pz;
  logic signed [37:0]         m_cx;
  logic signed [37:0]         m_cy;
  logic signed [37:0]         m_sy;
  logic signed [37:0]         m_cz;
  logic signed [37:0]         m_sz;
  logic signed [63:0]         rpx;
  logic signed [63:0]         rpy;
  logic signed [63:0]         rpz;

  assign en            = !vld[VLAT] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[VLAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[VLAT-1:0], s_axis_tvalid && s_axis_tuser};
    end
  end

  // direction delay line; taps feed the divider and the cross products
  always_ff @(posedge clk) begin
    if (en) begin
      dl[0].kx <= $signed(s_axis_tdata[15:0]);
      dl[0].ky <= $signed(s_axis_tdata[31:16]);
      dl[0].kz <= $signed(s_axis_tdata[47:32]);
      ang0     <= s_axis_tdata[63:48];
      for (int i = 1; i <= T_DIV; i++) dl[i] <= dl[i-1];
      m2 <= 32'(dl[0].ky * dl[0].ky) + 32'(dl[0].kz * dl[0].kz);
    end
  end

  ppv_sqrt u_sqrt (
    .clk (clk),
    .en  (en),
    .m2  (m2),
    .len (len)
  );

  assign num_y = -$signed({dl[T_SQ].kz[15], dl[T_SQ].kz});
  assign num_z = $signed({dl[T_SQ].ky[15], dl[T_SQ].ky});

  ppv_div u_div_y (
    .clk  (clk),
    .en   (en),
    .num  (num_y),
    .len  (len),
    .quot (ey_d)
  );

  ppv_div u_div_z (
    .clk  (clk),
    .en   (en),
    .num  (num_z),
    .len  (len),
    .quot (ez_d)
  );

  ppv_cordic u_cordic (
    .clk        (clk),
    .en         (en),
    .turn_angle (ang0),
    .cs         (cs_c)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      zl[0] <= (len == '0);
      for (int i = 1; i < Z_DLY; i++) zl[i] <= zl[i-1];
      csl[0] <= cs_c;
      for (int i = 1; i < CS_DLY; i++) csl[i] <= csl[i-1];
    end
  end

  // zero cross product: fall back to the z axis
  assign ey_f = zl[Z_DLY-1] ? '0 : ey_d;
  assign ez_f = zl[Z_DLY-1] ? (QB+1)'(ppv_pkg::ONE_Q) : ez_d;

  always_ff @(posedge clk) begin
    if (en) begin
      ey43 <= ey_f;
      ez43 <= ez_f;
      pa   <= ey_f * dl[T_DIV].kz;
      pb   <= ez_f * dl[T_DIV].ky;
      pc   <= ez_f * dl[T_DIV].kx;
      pd   <= ey_f * dl[T_DIV].kx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ey44 <= ey43;
      ez44 <= ez43;
      px   <= 20'(ppv_pkg::rnd_shift(64'(pa) - 64'(pb), F));
      py   <= 20'(ppv_pkg::rnd_shift(64'(pc), F));
      pz   <= 20'(ppv_pkg::rnd_shift(-64'(pd), F));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_cx <= csl[CS_DLY-1].co * px;
      m_cy <= csl[CS_DLY-1].co * py;
      m_sy <= csl[CS_DLY-1].si * ey44;
      m_cz <= csl[CS_DLY-1].co * pz;
      m_sz <= csl[CS_DLY-1].si * ez44;
    end
  end

  assign rpx = ppv_pkg::rnd_shift(64'(m_cx), F);
  assign rpy = ppv_pkg::rnd_shift(64'(m_cy) + 64'(m_sy), F);
  assign rpz = ppv_pkg::rnd_shift(64'(m_cz) + 64'(m_sz), F);

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {ppv_pkg::sat16(rpz), ppv_pkg::sat16(rpy), ppv_pkg::sat16(rpx)};
    end
  end

  // a non-optical transaction must not enter the pipeline
  a_drop_non_optical: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> !vld[0])
    else $error("non-optical transaction entered the pipeline");

  // a stalled pipeline keeps every valid bit in place
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved during a stall");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
                       $signed(m_axis_tdata[15:0]) >= -16'sd16384 &&
                       $signed(m_axis_tdata[31:16]) <= 16'sd16384 &&
                       $signed(m_axis_tdata[31:16]) >= -16'sd16384 &&
                       $signed(m_axis_tdata[47:32]) <= 16'sd16384 &&
                       $signed(m_axis_tdata[47:32]) >= -16'sd16384))
    else $error("result outside the saturation range");

endmodule

### sv/ppv_sqrt.sv
module ppv_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [31:0]                 m2,
  output logic [ppv_pkg::LEN_W-1:0]   len
);

  localparam int N = ppv_pkg::SQRT_STAGES;

  logic [47:0] rem_q [1:N-1];
  logic [47:0] res_q [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [47:0] BIT = 48'd1 << (2 * (N - 1 - k));
    logic [47:0] rem_i;
    logic [47:0] res_i;
    logic [47:0] trial;
    if (k == 0) begin : g_first
      assign rem_i = {m2, 16'd0};
      assign res_i = '0;
    end else begin : g_rest
      assign rem_i = rem_q[k];
      assign res_i = res_q[k];
    end
    assign trial = res_i + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_i >= trial) begin
          res_q[k+1] <= (res_i >> 1) + BIT;
        end else begin
          res_q[k+1] <= res_i >> 1;
        end
      end
    end

    if (k < N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k+1] <= (rem_i >= trial) ? rem_i - trial : rem_i;
        end
      end
    end
  end

  assign len = res_q[N][ppv_pkg::LEN_W-1:0];

endmodule

### sv/ppv_div.sv
module ppv_div (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [16:0]                  num,
  input  logic [ppv_pkg::LEN_W-1:0]           len,
  output logic signed [ppv_pkg::QUOT_BITS:0]  quot
);

  localparam int QB = ppv_pkg::QUOT_BITS;
  localparam int W  = ppv_pkg::DIVIDEND_W + 2;

  logic [16:0]                 mag;
  logic                        neg_q [0:QB];
  logic [W-1:0]                rem_q [0:QB-1];
  logic [ppv_pkg::LEN_W-1:0]   len_q [0:QB-1];
  logic [QB-1:0]               q_q   [0:QB];

  assign mag = num[16] ? 17'(-num) : 17'(num);

  // dividend carries the rounding half of the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= (W'(mag) << (ppv_pkg::FRAC_BITS + 8)) + W'(len >> 1);
      len_q[0] <= len;
      neg_q[0] <= num[16];
      q_q[0]   <= '0;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int B = QB - 1 - j;
    logic [W-1:0] dsh;
    logic         take;
    assign dsh  = W'(len_q[j]) << B;
    assign take = rem_q[j] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        q_q[j+1]   <= take ? (q_q[j] | (QB'(1) << B)) : q_q[j];
        neg_q[j+1] <= neg_q[j];
      end
    end

    if (j < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[j+1] <= take ? rem_q[j] - dsh : rem_q[j];
          len_q[j+1] <= len_q[j];
        end
      end
    end
  end

  assign quot = neg_q[QB] ? -$signed({1'b0, q_q[QB]}) : $signed({1'b0, q_q[QB]});

endmodule

### sv/ppv_cordic.sv
module ppv_cordic (
  input  logic                 clk,
  input  logic                 en,
  input  logic [15:0]          turn_angle,
  output ppv_pkg::cs_t         cs
);

  localparam int N = ppv_pkg::CORDIC_STEPS;
  localparam int RS = 30 - ppv_pkg::FRAC_BITS;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic [31:0]         ang32;
  logic signed [33:0]  x_q [0:N];
  logic signed [33:0]  y_q [0:N];
  logic signed [32:0]  z_q [0:N-1];
  logic [1:0]          quad_q [0:N];
  logic signed [63:0]  c_r;
  logic signed [63:0]  s_r;

  assign ang32 = 32'(turn_angle[ppv_pkg::ANGLE_BITS-1:0]) << (32 - ppv_pkg::ANGLE_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0]    <= ppv_pkg::CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= $signed({3'b000, ang32[29:0]});
      quad_q[0] <= ang32[31:30];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [32:0] at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = $signed({1'b0, ppv_pkg::ATAN_TURN[i]});

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_q[i][32]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
        end
        quad_q[i+1] <= quad_q[i];
      end
    end

    if (i < N - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) begin
          z_q[i+1] <= z_q[i][32] ? z_q[i] + at : z_q[i] - at;
        end
      end
    end
  end

  assign c_r = ppv_pkg::rnd_shift(64'(x_q[N]), RS);
  assign s_r = ppv_pkg::rnd_shift(64'(y_q[N]), RS);

  // fold the quadrant back by swap and negate
  always_ff @(posedge clk) begin
    if (en) begin
      unique case (quad_q[N])
        QUAD_0: begin
          cs.co <= c_r[ppv_pkg::CS_W-1:0];
          cs.si <= s_r[ppv_pkg::CS_W-1:0];
        end
        QUAD_1: begin
          cs.co <= -s_r[ppv_pkg::CS_W-1:0];
          cs.si <= c_r[ppv_pkg::CS_W-1:0];
        end
        QUAD_2: begin
          cs.co <= -c_r[ppv_pkg::CS_W-1:0];
          cs.si <= -s_r[ppv_pkg::CS_W-1:0];
        end
        QUAD_3: begin
          cs.co <= s_r[ppv_pkg::CS_W-1:0];
          cs.si <= -c_r[ppv_pkg::CS_W-1:0];
        end
        default: begin
          cs.co <= c_r[ppv_pkg::CS_W-1:0];
          cs.si <= s_r[ppv_pkg::CS_W-1:0];
        end
      endcase
    end
  end

endmodule
